### rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gmr_pkg.sv
`timescale 1ns / 1ps

package gmr_pkg;

    localparam int OP_W       = 3;
    localparam int ROW_W      = 8;
    localparam int COL_W      = 9;
    localparam int RCNT_W     = 9;
    localparam int CCNT_W     = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 10;
    localparam int ITER_W     = 9;
    // word index of a 9-bit column with at least 8 bits per word
    localparam int QW         = COL_W - 3;
    // reciprocal scaling for column to word split
    localparam int RECIP_SH   = 18;

    localparam logic [RCNT_W-1:0] ROW_COUNT_RST = 9'd256;
    localparam logic [CCNT_W-1:0] COL_COUNT_RST = 10'd512;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 8'd1;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_XOR   = 3'd2,
        OP_RSWAP = 3'd3,
        OP_CSWAP = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEC1,
        ST_DEC2,
        ST_RA,
        ST_RB,
        ST_WA,
        ST_WB,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic decode1;
        logic decode2;
        logic rd_a;
        logic rd_b;
        logic wr_a;
        logic wr_b;
        logic step;
        logic clear_wr;
        logic result;
    } cmd_t;

    typedef struct packed {
        logic ok;
        logic skip;
        logic bit_op;
        logic two_writes;
        logic last;
        logic clear_last;
        logic out_free;
    } status_t;

endpackage

### rtl/gmr_ram.sv
`timescale 1ns / 1ps

module gmr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/gmr_ctrl.sv
`timescale 1ns / 1ps

module gmr_ctrl import gmr_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DEC1;
                end
            end
            ST_DEC1:
            begin
                state_next = ST_DEC2;
            end
            ST_DEC2:
            begin
                state_next = (status.ok && !status.skip) ? ST_RA : ST_FIN;
            end
            ST_RA:
            begin
                state_next = status.bit_op ? ST_WA : ST_RB;
            end
            ST_RB:
            begin
                state_next = ST_WA;
            end
            ST_WA:
            begin
                if (status.bit_op)
                begin
                    state_next = ST_FIN;
                end
                else if (status.two_writes)
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    state_next = status.last ? ST_FIN : ST_RA;
                end
            end
            ST_WB:
            begin
                state_next = status.last ? ST_FIN : ST_RA;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DEC1:
            begin
                cmd.decode1 = 1'b1;
            end
            ST_DEC2:
            begin
                cmd.decode2 = 1'b1;
            end
            ST_RA:
            begin
                cmd.rd_a = 1'b1;
            end
            ST_RB:
            begin
                cmd.rd_b = 1'b1;
            end
            ST_WA:
            begin
                cmd.wr_a = 1'b1;
                // last write of a word or row moves to the next one
                cmd.step = !status.bit_op && !status.two_writes;
            end
            ST_WB:
            begin
                cmd.wr_b = 1'b1;
                cmd.step = 1'b1;
            end
            ST_FIN:
            begin
                cmd.result = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/gmr_datapath.sv
`timescale 1ns / 1ps

module gmr_datapath import gmr_pkg::*; #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_COLS  = 512,
    parameter int ROW_WORDS = 8,
    parameter int WORD_BITS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cmd_t                                  cmd,
    output status_t                               status,
    input  logic                                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [CFG_DATA_W-1:0]                 cfg_data,
    input  logic [OP_W-1:0]                       op,
    input  logic [ROW_W-1:0]                      row_a,
    input  logic [ROW_W-1:0]                      row_b,
    input  logic [COL_W-1:0]                      col_a,
    input  logic [COL_W-1:0]                      col_b,
    input  logic                                  bit_value,
    output logic                                  ram_re,
    output logic [$clog2(MAX_ROWS*ROW_WORDS)-1:0] ram_raddr,
    input  logic [WORD_BITS-1:0]                  ram_rdata,
    output logic                                  ram_we,
    output logic [$clog2(MAX_ROWS*ROW_WORDS)-1:0] ram_waddr,
    output logic [WORD_BITS-1:0]                  ram_wdata,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  read_bit,
    output logic                                  accepted
);

    localparam int TOTAL   = MAX_ROWS * ROW_WORDS;
    localparam int AW      = $clog2(TOTAL);
    localparam int SW      = $clog2(WORD_BITS);
    localparam int ROW_BITS = ROW_WORDS * WORD_BITS;
    localparam int COL_CAP = (MAX_COLS < ROW_BITS) ? MAX_COLS : ROW_BITS;
    localparam int RECIP   = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PW      = COL_W + 16;

    // configuration
    logic [RCNT_W-1:0] row_count_reg;
    logic [CCNT_W-1:0] col_count_reg;
    logic [RCNT_W-1:0] nr;

    // captured request
    op_t               op_reg;
    logic [ROW_W-1:0]  ra_reg;
    logic [ROW_W-1:0]  rb_reg;
    logic [COL_W-1:0]  ca_reg;
    logic [COL_W-1:0]  cb_reg;
    logic              bv_reg;
    logic              ok_reg;
    logic              skip_reg;

    // decoded addressing
    logic [AW-1:0]     base_a_reg;
    logic [AW-1:0]     base_b_reg;
    logic [QW-1:0]     qa_reg;
    logic [QW-1:0]     qb_reg;
    logic [SW-1:0]     sa_reg;
    logic [SW-1:0]     sb_reg;
    logic [AW-1:0]     addr_a_reg;
    logic [AW-1:0]     addr_b_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [ITER_W-1:0] iter_last_reg;

    logic [WORD_BITS-1:0] hold_a_reg;
    logic [WORD_BITS-1:0] hold_b_reg;
    logic                 rbit_reg;
    logic [AW-1:0]        clr_addr_reg;

    logic out_valid_reg;
    logic read_bit_reg;
    logic accepted_reg;

    logic          row_ok_a;
    logic          row_ok_b;
    logic          col_ok_a;
    logic          col_ok_b;
    logic          ok_in;
    logic          skip_in;
    logic [PW-1:0] prod_a;
    logic [PW-1:0] prod_b;
    logic          is_bit_op;
    logic          same_word;
    logic [WORD_BITS-1:0] word_a;
    logic [WORD_BITS-1:0] word_b;

    assign nr = (32'(row_count_reg) > 32'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS) : row_count_reg;

    assign row_ok_a = ({1'b0, row_a} < row_count_reg) && (32'(row_a) < 32'(MAX_ROWS));
    assign row_ok_b = ({1'b0, row_b} < row_count_reg) && (32'(row_b) < 32'(MAX_ROWS));
    assign col_ok_a = ({1'b0, col_a} < col_count_reg) && (32'(col_a) < 32'(COL_CAP));
    assign col_ok_b = ({1'b0, col_b} < col_count_reg) && (32'(col_b) < 32'(COL_CAP));

    always_comb
    begin
        case (op_t'(op)) inside
            OP_READ, OP_WRITE: ok_in = row_ok_a && col_ok_a;
            OP_XOR, OP_RSWAP:  ok_in = row_ok_a && row_ok_b;
            OP_CSWAP:          ok_in = col_ok_a && col_ok_b;
            default:           ok_in = 1'b0;
        endcase
    end

    // equal swaps and a column swap over no rows leave the memory alone
    assign skip_in = ((op_t'(op) == OP_RSWAP) && (row_a == row_b))
                  || ((op_t'(op) == OP_CSWAP) && ((col_a == col_b) || (nr == '0)));

    // column to word index by reciprocal multiply, exact for 9-bit columns
    assign prod_a = PW'(ca_reg) * PW'(RECIP);
    assign prod_b = PW'(cb_reg) * PW'(RECIP);

    assign is_bit_op = (op_reg == OP_READ) || (op_reg == OP_WRITE);
    assign same_word = (qa_reg == qb_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_ROW_COUNT))
            begin
                row_count_reg <= cfg_data[RCNT_W-1:0];
            end
            if (cfg_valid && (cfg_index == CFG_COL_COUNT))
            begin
                col_count_reg <= cfg_data;
            end
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_t'(op);
            ra_reg   <= row_a;
            rb_reg   <= row_b;
            ca_reg   <= col_a;
            cb_reg   <= col_b;
            bv_reg   <= bit_value;
            ok_reg   <= ok_in;
            skip_reg <= skip_in;
            rbit_reg <= 1'b0;
        end
        if (cmd.decode1)
        begin
            base_a_reg <= AW'(ra_reg) * AW'(ROW_WORDS);
            base_b_reg <= AW'(rb_reg) * AW'(ROW_WORDS);
            qa_reg     <= QW'(prod_a >> RECIP_SH);
            qb_reg     <= QW'(prod_b >> RECIP_SH);
        end
        if (cmd.decode2)
        begin
            sa_reg     <= SW'(ca_reg - COL_W'(qa_reg) * COL_W'(WORD_BITS));
            sb_reg     <= SW'(cb_reg - COL_W'(qb_reg) * COL_W'(WORD_BITS));
            iter_reg   <= '0;
            case (op_reg) inside
                OP_CSWAP:
                begin
                    addr_a_reg    <= AW'(qa_reg);
                    addr_b_reg    <= AW'(qb_reg);
                    iter_last_reg <= nr - ITER_W'(1);
                end
                OP_XOR, OP_RSWAP:
                begin
                    addr_a_reg    <= base_a_reg;
                    addr_b_reg    <= base_b_reg;
                    iter_last_reg <= ITER_W'(ROW_WORDS - 1);
                end
                default:
                begin
                    addr_a_reg    <= base_a_reg + AW'(qa_reg);
                    addr_b_reg    <= base_b_reg + AW'(qb_reg);
                    iter_last_reg <= '0;
                end
            endcase
        end
        if (cmd.rd_b)
        begin
            hold_a_reg <= ram_rdata;
        end
        if (cmd.wr_a)
        begin
            hold_b_reg <= ram_rdata;
            if (op_reg == OP_READ)
            begin
                rbit_reg <= ram_rdata[sa_reg];
            end
        end
        if (cmd.step)
        begin
            iter_reg <= iter_reg + ITER_W'(1);
            // next word of the row, or same columns in the next row
            if (op_reg == OP_CSWAP)
            begin
                addr_a_reg <= addr_a_reg + AW'(ROW_WORDS);
                addr_b_reg <= addr_b_reg + AW'(ROW_WORDS);
            end
            else
            begin
                addr_a_reg <= addr_a_reg + AW'(1);
                addr_b_reg <= addr_b_reg + AW'(1);
            end
        end
        if (cmd.result)
        begin
            read_bit_reg <= rbit_reg;
            accepted_reg <= ok_reg;
        end
    end

    // word written back in the first write slot
    always_comb
    begin
        word_a = ram_rdata;
        case (op_reg)
            OP_WRITE:
            begin
                word_a         = ram_rdata;
                word_a[sa_reg] = bv_reg;
            end
            OP_XOR:
            begin
                word_a = hold_a_reg ^ ram_rdata;
            end
            OP_RSWAP:
            begin
                word_a = ram_rdata;
            end
            OP_CSWAP:
            begin
                word_a = hold_a_reg;
                if (same_word)
                begin
                    word_a[sa_reg] = hold_a_reg[sb_reg];
                    word_a[sb_reg] = hold_a_reg[sa_reg];
                end
                else
                begin
                    word_a[sa_reg] = ram_rdata[sb_reg];
                end
            end
            default:
            begin
                word_a = ram_rdata;
            end
        endcase
    end

    // word written back in the second write slot
    always_comb
    begin
        if (op_reg == OP_RSWAP)
        begin
            word_b = hold_a_reg;
        end
        else
        begin
            word_b         = hold_b_reg;
            word_b[sb_reg] = hold_a_reg[sa_reg];
        end
    end

    assign ram_re    = cmd.rd_a | cmd.rd_b;
    assign ram_raddr = cmd.rd_b ? addr_b_reg : addr_a_reg;
    assign ram_we    = cmd.clear_wr | (cmd.wr_a & (op_reg != OP_READ)) | cmd.wr_b;

    always_comb
    begin
        if (cmd.clear_wr)
        begin
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (cmd.wr_b)
        begin
            ram_waddr = addr_b_reg;
            ram_wdata = word_b;
        end
        else
        begin
            ram_waddr = addr_a_reg;
            ram_wdata = word_a;
        end
    end

    assign status.ok         = ok_reg;
    assign status.skip       = skip_reg;
    assign status.bit_op     = is_bit_op;
    assign status.two_writes = (op_reg == OP_RSWAP) || ((op_reg == OP_CSWAP) && !same_word);
    assign status.last       = (iter_reg == iter_last_reg);
    assign status.clear_last = (clr_addr_reg == AW'(TOTAL - 1));
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign read_bit  = read_bit_reg;
    assign accepted  = accepted_reg;

endmodule

### rtl/gf2_matrix_row_engine.sv
// Bit-packed GF(2) matrix held in a single-port-read word memory, one request at a time.
// After reset the memory is zeroed by a clearing pass over all MAX_ROWS*ROW_WORDS words
// with in_ready low; config writes are taken throughout. A taken request is decoded in
// states DEC1 and DEC2; then each word it touches is read through the memory's one read
// port and, but for a bit read, written back. A rejected or no-change request skips the
// memory. in_ready returns the cycle after the result is loaded; a waiting result does
// not hold off the next request.
`timescale 1ns / 1ps

module gf2_matrix_row_engine import gmr_pkg::*; #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_COLS  = 512,
    parameter int ROW_WORDS = 8,
    parameter int WORD_BITS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       op,
    input  logic [ROW_W-1:0]      row_a,
    input  logic [ROW_W-1:0]      row_b,
    input  logic [COL_W-1:0]      col_a,
    input  logic [COL_W-1:0]      col_b,
    input  logic                  bit_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  read_bit,
    output logic                  accepted
);

    localparam int DEPTH = MAX_ROWS * ROW_WORDS;
    localparam int AW    = $clog2(DEPTH);

    cmd_t    cmd;
    status_t status;

    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;

    assign cfg_ready = 1'b1;

    gmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    gmr_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .ROW_WORDS (ROW_WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (op),
        .row_a     (row_a),
        .row_b     (row_b),
        .col_a     (col_a),
        .col_b     (col_b),
        .bit_value (bit_value),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_bit  (read_bit),
        .accepted  (accepted)
    );

    gmr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

### rtl/gmr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gmr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic read_bit,
    input logic accepted
);

    // a stalled result keeps its payload
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(read_bit) && $stable(accepted), "result changed while stalled")

    // a set read bit only comes from an operation that ran
    `ASSERT_IMPLIES(a_read_accepted, clk, rst_n, out_valid && read_bit, accepted, "read bit set on a rejected request")

    // one request in flight at a time
    `ASSERT_NEXT(a_single_request, clk, rst_n, in_valid && in_ready, !in_ready, "ready right after a request was taken")

    // a new result never shows up the cycle after the engine was idle
    `ASSERT_IMPLIES(a_result_after_work, clk, rst_n, $rose(out_valid), !$past(in_ready), "result loaded straight out of idle")

endmodule

bind gf2_matrix_row_engine gmr_checker u_gmr_checker (.*);
